/* hdl/bd_pkg.sv */
// Package for the bounded deque: sizes, operation codes and shared types.
// Used by the channel interfaces and by the bounded_deque top level.
`timescale 1ns / 1ps

package bd_pkg;

  // Ring store size and word width.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = 5;
  localparam int CAP_W      = 5;
  localparam int FUNC_W     = 2;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_BACK   = 2'd2,
    FUNC_POP_FRONT  = 2'd3
  } func_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Next and previous slot in the ring.
  function automatic addr_t slot_next(addr_t a);
    addr_t r;
    if (a == addr_t'(DEPTH - 1)) r = '0;
    else                         r = a + addr_t'(1);
    return r;
  endfunction

  function automatic addr_t slot_prev(addr_t a);
    addr_t r;
    if (a == '0) r = addr_t'(DEPTH - 1);
    else         r = a - addr_t'(1);
    return r;
  endfunction

endpackage

/* hdl/bd_if.sv */
// Valid/ready channel interfaces of the bounded deque: request, response, config.
// Depends on bd_pkg for widths.
`timescale 1ns / 1ps

interface bd_req_if import bd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface bd_rsp_if import bd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [DATA_WIDTH-1:0] pop_value;
  logic [CNT_W-1:0]      count_now;

  modport source (output valid, output ok, output pop_value, output count_now,
                  input ready);
  modport sink   (input valid, input ok, input pop_value, input count_now,
                  output ready);
endinterface

interface bd_cfg_if import bd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

/* hdl/bounded_deque.sv */
// Top level of the bounded deque: ring store memory, pointers and result stages.
// Depends on bd_pkg and the channel interfaces in bd_if.sv.
`timescale 1ns / 1ps

// A bounded double-ended queue of 32-bit words in a 16-entry ring store.
// Each request item pushes or pops at either end; each produces exactly one
// response item with a success flag, the popped word (zero otherwise) and
// the count after the operation. Pointers and the count update at the edge
// that accepts the item, and the store is read or written at that same edge,
// so an item may be accepted every cycle unless both result stages are full
// and the response is stalled. A response passes through the registered memory
// read and then the output register. The capacity register may be written at any time the deque is
// idle; values above 16 act as 16 and zero makes every push fail.

module bounded_deque
  import bd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bd_req_if.sink       req,
  bd_rsp_if.source     rsp,
  bd_cfg_if.sink       cfg
);

  // Ring store, read data registered.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  // Pointers, count and capacity.
  addr_t            front_index;
  addr_t            back_index;
  count_t           entry_count;
  logic [CAP_W-1:0] capacity;

  // Stage after acceptance, waiting on the memory read.
  logic   s1_valid;
  logic   s1_ok;
  logic   s1_pop;
  count_t s1_count;

  // Decoded request.
  func_t                 op;
  logic                  is_push;
  count_t                limit;
  logic                  op_ok;
  logic                  accept;
  logic                  advance;
  logic                  wr_en;
  logic                  rd_en;
  addr_t                 wr_addr;
  addr_t                 rd_addr;
  addr_t                 front_index_next;
  addr_t                 back_index_next;
  count_t                entry_count_next;

  assign cfg.ready = 1'b1;

  // The first stage moves on when the output register is empty or drained.
  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Decode the operation and decide whether it succeeds.
  always_comb begin
    op      = func_t'(req.func);
    is_push = (op == FUNC_PUSH_BACK) || (op == FUNC_PUSH_FRONT);
    if (capacity > CAP_W'(DEPTH)) limit = count_t'(DEPTH);
    else                          limit = count_t'(capacity);
    if (is_push) op_ok = entry_count < limit;
    else         op_ok = entry_count != '0;
  end

  // Next pointers and memory addresses for the accepted item.
  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    entry_count_next = entry_count;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    wr_addr          = back_index;
    rd_addr          = front_index;
    if (accept && op_ok) begin
      unique case (op)
        FUNC_PUSH_BACK: begin
          wr_en            = 1'b1;
          wr_addr          = back_index;
          back_index_next  = slot_next(back_index);
          entry_count_next = entry_count + count_t'(1);
        end
        FUNC_PUSH_FRONT: begin
          wr_en            = 1'b1;
          wr_addr          = slot_prev(front_index);
          front_index_next = slot_prev(front_index);
          entry_count_next = entry_count + count_t'(1);
        end
        FUNC_POP_BACK: begin
          rd_en            = 1'b1;
          rd_addr          = slot_prev(back_index);
          back_index_next  = slot_prev(back_index);
          entry_count_next = entry_count - count_t'(1);
        end
        FUNC_POP_FRONT: begin
          rd_en            = 1'b1;
          rd_addr          = front_index;
          front_index_next = slot_next(front_index);
          entry_count_next = entry_count - count_t'(1);
        end
        default: ;
      endcase
    end
  end

  // Ring store: at most one write or one read per accepted item.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= req.push_value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Control state, capacity and the two result stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      entry_count <= '0;
      capacity    <= CAP_RESET;
      s1_valid    <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      entry_count <= entry_count_next;
      if (cfg.valid && cfg.ready) capacity <= cfg.capacity;

      if (accept)       s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;

      if (advance)        rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // Payload of the result stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= op_ok;
      s1_pop   <= !is_push;
      s1_count <= entry_count_next;
    end
    if (advance) begin
      rsp.ok        <= s1_ok;
      rsp.pop_value <= (s1_ok && s1_pop) ? rd_data : '0;
      rsp.count_now <= s1_count;
    end
  end

  // The count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= count_t'(DEPTH))
    else $error("entry count exceeds depth");

  // Pointer distance matches the count modulo the depth.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    addr_t'(back_index - front_index) == addr_t'(entry_count))
    else $error("pointers disagree with count");

  // The count moves by at most one per accepted item, and not at all otherwise.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> entry_count == $past(entry_count))
    else $error("count changed without an item");

  // Requests are refused only while both result stages are full and stalled.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && rsp.valid && !rsp.ready))
    else $error("request refused without a stall");

  // A stalled successful pop keeps its memory read data.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ok && s1_pop && !advance) |=> $stable(rd_data))
    else $error("pending read data lost during stall");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for bounded_deque: directed and random push/pop items
// with random stalls on both channels, checked against an in-bench deque model.
// Depends on bd_pkg, the channel interfaces in bd_if.sv and the bounded_deque top.
`timescale 1ns / 1ps

module testbench
  import bd_pkg::*;
();

  // One request item waiting to be driven.
  typedef struct packed {
    func_t                 op;
    logic [DATA_WIDTH-1:0] word;
  } deque_op_t;

  // One expected response item.
  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] pop_value;
    count_t                count_now;
  } deque_result_t;

  logic clk;
  logic rst;

  bd_req_if req_ch ();
  bd_rsp_if rsp_ch ();
  bd_cfg_if cfg_ch ();

  bounded_deque i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Items still to be driven and responses still owed by the block.
  deque_op_t     pending_ops[$];
  deque_result_t owed_results[$];

  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned errors_seen    = 0;

  // Handshakes seen at the last rising edge.
  bit req_taken = 1'b0;
  bit cfg_taken = 1'b0;

  // Idling control for both channels.
  bit idle_on = 1'b1;
  int send_gap  = 0;
  int send_calm = 0;
  int recv_gap  = 0;
  int recv_calm = 0;
  bit send_hold;
  bit recv_hold;
  deque_op_t next_op;

  // Shadow copy of the deque state and its capacity register.
  logic [DATA_WIDTH-1:0] ring_words[DEPTH];
  addr_t                 head_slot = '0;
  addr_t                 tail_slot = '0;
  count_t                held      = '0;
  logic [CAP_W-1:0]      cap_reg   = CAP_RESET;

  // Clock and the single reset at the start.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_PUSH_BACK;
    req_ch.push_value  = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.capacity    = CAP_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Move a ring slot by one step in either direction.
  function automatic addr_t step_slot(addr_t s, int d);
    return addr_t'((int'(s) + d + DEPTH) % DEPTH);
  endfunction

  // Apply one operation to the shadow deque and return its response.
  function automatic deque_result_t predict_deque(func_t op, logic [DATA_WIDTH-1:0] word);
    deque_result_t r;
    int            lim;
    r.ok        = 1'b0;
    r.pop_value = '0;
    lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    case (op)
      FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
        if (int'(held) < lim) begin
          if (op == FUNC_PUSH_BACK) begin
            ring_words[tail_slot] = word;
            tail_slot = step_slot(tail_slot, 1);
          end else begin
            head_slot = step_slot(head_slot, -1);
            ring_words[head_slot] = word;
          end
          held = held + count_t'(1);
          r.ok = 1'b1;
        end
      end
      FUNC_POP_BACK, FUNC_POP_FRONT: begin
        if (held != '0) begin
          if (op == FUNC_POP_BACK) begin
            tail_slot = step_slot(tail_slot, -1);
            r.pop_value = ring_words[tail_slot];
          end else begin
            r.pop_value = ring_words[head_slot];
            head_slot = step_slot(head_slot, 1);
          end
          held = held - count_t'(1);
          r.ok = 1'b1;
        end
      end
    endcase
    r.count_now = held;
    return r;
  endfunction

  // Request driver: presents the next pending item, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      send_hold = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        send_hold = 1'b1;
      end else if (idle_on) begin
        if (send_calm > 0) begin
          send_calm--;
        end else if ($urandom_range(0, 7) == 0) begin
          send_gap  = $urandom_range(0, 16);
          send_hold = 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
          send_calm = $urandom_range(10, 60);
        end
      end
      if (!send_hold && pending_ops.size() > 0) begin
        next_op = pending_ops[0];
        pending_ops.delete(0);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= next_op.op;
        req_ch.push_value <= next_op.word;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stall bursts, none in the last part of the run.
  always @(negedge clk) begin
    recv_hold = 1'b0;
    if (recv_gap > 0) begin
      recv_gap--;
      recv_hold = 1'b1;
    end else if (idle_on) begin
      if (recv_calm > 0) begin
        recv_calm--;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_gap  = $urandom_range(0, 16);
        recv_hold = 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        recv_calm = $urandom_range(10, 60);
      end
    end
    rsp_ch.ready <= !recv_hold;
  end

  // Monitor: predicts on accepted requests and checks accepted responses.
  always @(posedge clk) begin
    deque_result_t want;
    req_taken = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
    cfg_taken = (cfg_ch.valid === 1'b1) && (cfg_ch.ready === 1'b1);
    if (!rst) begin
      if (cfg_taken) cap_reg = cfg_ch.capacity;
      if (req_taken) begin
        owed_results.insert(owed_results.size(),
                            predict_deque(func_t'(req_ch.func), req_ch.push_value));
        accepted_items++;
      end
      if ((rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1)) begin
        if (owed_results.size() == 0) begin
          $error("response item with no request outstanding");
          errors_seen++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (rsp_ch.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
            errors_seen++;
          end
          if (rsp_ch.pop_value !== want.pop_value) begin
            $error("pop_value: expected 0x%08h, got 0x%08h", want.pop_value,
                   rsp_ch.pop_value);
            errors_seen++;
          end
          if (rsp_ch.count_now !== want.count_now) begin
            $error("count_now: expected %0d, got %0d", want.count_now, rsp_ch.count_now);
            errors_seen++;
          end
        end
      end
    end
  end

  task automatic queue_op(func_t op, logic [DATA_WIDTH-1:0] word);
    deque_op_t item;
    item.op   = op;
    item.word = word;
    pending_ops.insert(pending_ops.size(), item);
    queued_items++;
  endtask

  // Wait until every queued item has been taken and answered.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || accepted_items != queued_items ||
           owed_results.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random items: alternating fill and drain stretches so the deque
  // repeatedly reaches both full and empty.
  task automatic random_phase(int n);
    int    seg_left;
    bit    filling;
    func_t op;
    logic [DATA_WIDTH-1:0] word;
    seg_left = 0;
    filling  = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 24);
        filling  = !filling;
      end
      seg_left--;
      if ($urandom_range(0, 9) < (filling ? 8 : 2))
        op = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      case ($urandom_range(0, 7))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      queue_op(op, word);
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [CAP_W-1:0] caps[10];
    @(negedge rst);

    // Empty pops, both ends, word extremes.
    queue_op(FUNC_POP_BACK, 32'h0000_0000);
    queue_op(FUNC_POP_FRONT, 32'hFFFF_FFFF);
    queue_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_op(FUNC_PUSH_BACK, 32'h0000_0000);
    queue_op(FUNC_PUSH_FRONT, 32'h1234_5678);
    queue_op(FUNC_PUSH_BACK, 32'h8000_0001);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_BACK, '0);
    queue_op(FUNC_POP_BACK, '0);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_FRONT, '0);
    wait_drained();

    // Capacity of one: the second push is dropped.
    write_capacity(CAP_W'(1));
    queue_op(FUNC_PUSH_BACK, 32'h5A5A_5A5A);
    queue_op(FUNC_PUSH_FRONT, 32'hA5A5_A5A5);
    queue_op(FUNC_POP_BACK, '0);
    wait_drained();

    // Capacity zero: every push fails.
    write_capacity(CAP_W'(0));
    queue_op(FUNC_PUSH_BACK, 32'h0F0F_0F0F);
    queue_op(FUNC_PUSH_FRONT, 32'hF0F0_F0F0);
    queue_op(FUNC_POP_FRONT, '0);
    wait_drained();

    // Capacity lowered below the count: held entries stay, pushes fail
    // until the count falls below the new limit.
    write_capacity(CAP_W'(16));
    for (int i = 0; i < 4; i++) queue_op(FUNC_PUSH_BACK, DATA_WIDTH'(32'hC000_0000 + i));
    wait_drained();
    write_capacity(CAP_W'(2));
    queue_op(FUNC_PUSH_FRONT, 32'hDEAD_0001);
    queue_op(FUNC_POP_BACK, '0);
    queue_op(FUNC_POP_BACK, '0);
    queue_op(FUNC_PUSH_FRONT, 32'hDEAD_0002);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_PUSH_FRONT, 32'hDEAD_0003);
    wait_drained();

    // Random phases over several capacities, including saturation above 16.
    caps[0] = CAP_W'(16);
    caps[1] = CAP_W'(1);
    caps[2] = CAP_W'(31);
    caps[3] = CAP_W'(0);
    caps[4] = CAP_W'(17);
    caps[5] = CAP_W'($urandom_range(2, 15));
    caps[6] = CAP_W'(5);
    caps[7] = CAP_W'($urandom_range(0, 31));
    caps[8] = CAP_W'($urandom_range(2, 15));
    caps[9] = CAP_W'(16);
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      if (p == 9) idle_on = 1'b0;
      random_phase(80);
      wait_drained();
    end

    // Let any stray response show up before the verdict.
    repeat (10) @(posedge clk);
    if (errors_seen == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
